[rtl/acs_pkg.sv]
// acs_pkg: shared constants, request codes and state type for the aging checkpoint selector
// no dependencies; used by acs_ram, acs_ctrl and aging_checkpoint_selector
package acs_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int AGE_WIDTH_DEF   = 16;

  localparam int REQ_W      = 3;
  localparam int IDX_PORT_W = 4;
  localparam int LAT_W      = 16;
  localparam int CFG_W      = 8;

  localparam logic [CFG_W-1:0] CFG_LATENCY_RESET = 8'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 3'd0,
    REQ_OPEN    = 3'd1,
    REQ_MODIFY  = 3'd2,
    REQ_OUTCOME = 3'd3,
    REQ_SET_LAT = 3'd4,
    REQ_CLOSE   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUTCOME
  } state_t;

endpackage

[rtl/acs_ram.sv]
// acs_ram: generic single-write, single-read synchronous ram with registered read data
// depends on acs_pkg for default sizes
module acs_ram #(
  parameter int WIDTH = 2 * acs_pkg::AGE_WIDTH_DEF,
  parameter int DEPTH = acs_pkg::NUM_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/acs_ctrl.sv]
// acs_ctrl: request sequencer, entry flag table and tick scan over the age/bias ram
// depends on acs_pkg; drives one acs_ram holding {age, bias} per entry
module acs_ctrl #(
  parameter int NUM_ENTRIES = acs_pkg::NUM_ENTRIES_DEF,
  parameter int AGE_WIDTH   = acs_pkg::AGE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [acs_pkg::REQ_W-1:0]           in_req_type,
  input  logic [acs_pkg::IDX_PORT_W-1:0]      in_entry_index,
  input  logic signed [acs_pkg::LAT_W-1:0]    in_latency_value,
  input  logic                                in_flag,
  input  logic [acs_pkg::CFG_W-1:0]           global_latency,
  output logic                                ram_we,
  output logic [$clog2(NUM_ENTRIES)-1:0]      ram_waddr,
  output logic [2*AGE_WIDTH-1:0]              ram_wdata,
  output logic [$clog2(NUM_ENTRIES)-1:0]      ram_raddr,
  input  logic [2*AGE_WIDTH-1:0]              ram_rdata,
  output logic                                out_valid,
  output logic                                out_chosen_valid,
  output logic [acs_pkg::IDX_PORT_W-1:0]      out_chosen_index
);

  localparam int IDX_W   = $clog2(NUM_ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int BEST_W  = AGE_WIDTH + 2;
  localparam int CLAMP_W = 34;
  localparam int DATA_W  = 2 * AGE_WIDTH;
  localparam logic signed [AGE_WIDTH-1:0] AGE_MAX = {1'b0, {(AGE_WIDTH-1){1'b1}}};

  acs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [BEST_W-1:0]   best_r, best_nxt;
  logic                       found_r, found_nxt;
  logic [IDX_W-1:0]           pick_r, pick_nxt;
  logic [IDX_W-1:0]           req_idx_r, req_idx_nxt;
  logic [NUM_ENTRIES-1:0]     valid_r, valid_nxt;
  logic [NUM_ENTRIES-1:0]     scratch_r, scratch_nxt;
  logic [NUM_ENTRIES-1:0]     dirty_r, dirty_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_chv_r, out_chv_nxt;
  logic [acs_pkg::IDX_PORT_W-1:0] out_idx_r, out_idx_nxt;

  logic                       in_range;
  logic [IDX_W-1:0]           in_idx;
  logic                       live;
  logic signed [CLAMP_W-1:0]  lat_ext;
  logic signed [CLAMP_W-1:0]  lat_max;
  logic signed [CLAMP_W-1:0]  lat_min;
  logic signed [CLAMP_W-1:0]  lat_clamped;
  logic signed [AGE_WIDTH-1:0] lat_age;
  logic [IDX_W-1:0]           d_idx;
  logic signed [AGE_WIDTH-1:0] rd_age;
  logic [AGE_WIDTH-1:0]       rd_bias;
  logic signed [AGE_WIDTH-1:0] age_inc;
  logic signed [BEST_W-1:0]   age_ext;
  logic signed [BEST_W-1:0]   best_init;
  logic                       qual;
  logic                       wins;
  logic                       scan_last;

  // request decode
  assign in_range = int'(in_entry_index) < NUM_ENTRIES;
  assign in_idx   = IDX_W'(in_entry_index);
  assign live     = in_range && valid_r[in_idx];

  // latency clamp to the signed age range
  assign lat_ext     = CLAMP_W'(in_latency_value);
  assign lat_max     = CLAMP_W'(AGE_MAX);
  assign lat_min     = ~lat_max;
  assign lat_clamped = (lat_ext > lat_max) ? lat_max :
                       (lat_ext < lat_min) ? lat_min : lat_ext;
  assign lat_age     = AGE_WIDTH'(lat_clamped);

  // scan data stage: ram data belongs to entry cnt_r - 1
  assign d_idx     = IDX_W'(cnt_r - CNT_W'(1));
  assign rd_age    = ram_rdata[DATA_W-1:AGE_WIDTH];
  assign rd_bias   = ram_rdata[AGE_WIDTH-1:0];
  assign age_inc   = (rd_age == AGE_MAX) ? rd_age : rd_age + AGE_WIDTH'(1);
  assign age_ext   = BEST_W'(rd_age);
  assign best_init = BEST_W'(global_latency) - BEST_W'(1);
  assign qual      = (cnt_r != '0) && valid_r[d_idx] && !scratch_r[d_idx] && dirty_r[d_idx];
  assign wins      = qual && (age_ext > best_r);
  assign scan_last = (cnt_r == CNT_W'(NUM_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      acs_pkg::ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            acs_pkg::REQ_TICK: begin
              state_nxt = acs_pkg::ST_SCAN;
            end
            acs_pkg::REQ_OUTCOME: begin
              if (live && in_flag) begin
                state_nxt = acs_pkg::ST_OUTCOME;
              end
            end
            default: begin
              state_nxt = acs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      acs_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_OUTCOME: begin
        state_nxt = acs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = acs_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    req_idx_nxt   = req_idx_r;
    valid_nxt     = valid_r;
    scratch_nxt   = scratch_r;
    dirty_nxt     = dirty_r;
    out_valid_nxt = 1'b0;
    out_chv_nxt   = 1'b0;
    out_idx_nxt   = '0;
    ram_we        = 1'b0;
    ram_waddr     = in_idx;
    ram_wdata     = '0;
    ram_raddr     = in_idx;
    case (state_r)
      acs_pkg::ST_IDLE: begin
        if (start) begin
          req_idx_nxt = in_idx;
          case (in_req_type)
            acs_pkg::REQ_TICK: begin
              cnt_nxt   = '0;
              best_nxt  = best_init;
              found_nxt = 1'b0;
              pick_nxt  = '0;
            end
            acs_pkg::REQ_OPEN: begin
              if (in_range) begin
                valid_nxt[in_idx]   = 1'b1;
                scratch_nxt[in_idx] = in_flag;
                dirty_nxt[in_idx]   = 1'b0;
                ram_we              = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            acs_pkg::REQ_MODIFY: begin
              if (live) begin
                dirty_nxt[in_idx] = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            acs_pkg::REQ_OUTCOME: begin
              out_valid_nxt = !(live && in_flag);
            end
            acs_pkg::REQ_SET_LAT: begin
              if (live) begin
                ram_we    = 1'b1;
                ram_wdata = {lat_age, lat_age};
              end
              out_valid_nxt = 1'b1;
            end
            acs_pkg::REQ_CLOSE: begin
              if (live) begin
                valid_nxt[in_idx] = 1'b0;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      acs_pkg::ST_SCAN: begin
        ram_raddr = cnt_r[IDX_W-1:0];
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (qual) begin
          ram_we    = 1'b1;
          ram_waddr = d_idx;
          ram_wdata = {age_inc, rd_bias};
        end
        if (wins) begin
          best_nxt  = age_ext;
          found_nxt = 1'b1;
          pick_nxt  = d_idx;
        end
        if (scan_last) begin
          out_valid_nxt = 1'b1;
          out_chv_nxt   = found_nxt;
          out_idx_nxt   = found_nxt ? acs_pkg::IDX_PORT_W'(pick_nxt) : '0;
        end
      end
      acs_pkg::ST_OUTCOME: begin
        ram_we               = 1'b1;
        ram_waddr            = req_idx_r;
        ram_wdata            = {rd_bias, rd_bias};
        dirty_nxt[req_idx_r] = 1'b0;
        out_valid_nxt        = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acs_pkg::ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      scratch_r   <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      out_chv_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      valid_r     <= valid_nxt;
      scratch_r   <= scratch_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      out_chv_r   <= out_chv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    pick_r    <= pick_nxt;
    req_idx_r <= req_idx_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign busy             = (state_r != acs_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_chosen_valid = out_chv_r;
  assign out_chosen_index = out_idx_r;

endmodule

[rtl/aging_checkpoint_selector.sv]
// aging_checkpoint_selector: latency register, sequencer and age/bias ram
// open, modify, latency and close beats answer from idle; a flagged outcome on a live entry uses ST_OUTCOME,
// and a tick scans one entry a cycle through the separate read and write ports of the ram
// busy is low again in the same cycle as the result beat of an outcome or a tick
// reset: synchronous active-low rst_n clears the flag table and sets global latency to 4
// results are one-cycle strobes on out_valid; the receiver cannot stall
module aging_checkpoint_selector #(
  parameter int NUM_ENTRIES = acs_pkg::NUM_ENTRIES_DEF,
  parameter int AGE_WIDTH   = acs_pkg::AGE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [acs_pkg::REQ_W-1:0]        in_req_type,
  input  logic [acs_pkg::IDX_PORT_W-1:0]   in_entry_index,
  input  logic signed [acs_pkg::LAT_W-1:0] in_latency_value,
  input  logic                             in_flag,
  input  logic                             cfg_we,
  input  logic [acs_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                             out_valid,
  output logic                             out_chosen_valid,
  output logic [acs_pkg::IDX_PORT_W-1:0]   out_chosen_index
);

  localparam int IDX_W  = $clog2(NUM_ENTRIES);
  localparam int DATA_W = 2 * AGE_WIDTH;

  logic [acs_pkg::CFG_W-1:0] global_latency_r;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [DATA_W-1:0]         ram_wdata;
  logic [IDX_W-1:0]          ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_latency_r <= acs_pkg::CFG_LATENCY_RESET;
    end else if (cfg_we) begin
      global_latency_r <= cfg_wdata;
    end
  end

  acs_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .AGE_WIDTH   (AGE_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_latency_value (in_latency_value),
    .in_flag          (in_flag),
    .global_latency   (global_latency_r),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_chosen_valid (out_chosen_valid),
    .out_chosen_index (out_chosen_index)
  );

  acs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // no result beat while a tick or outcome is in flight
  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result beat while busy");

  // every accepted beat either answers next cycle or goes busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted beat neither answered nor in flight");

  // leaving busy always delivers the result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without result beat");

  // no selection means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_chosen_valid) |-> (out_chosen_index == '0))
    else $error("nonzero index without selection");
`endif

endmodule

[verif/tb_aging_checkpoint_selector.sv]
// tb_aging_checkpoint_selector: self-checking bench for the aging checkpoint selector
// holds its own table model of flags, ages and biases, drives command beats and checks picks
// depends on rtl/acs_pkg.sv and rtl/aging_checkpoint_selector.sv
module tb_aging_checkpoint_selector;

  localparam int N           = acs_pkg::NUM_ENTRIES_DEF;
  localparam int AW          = acs_pkg::AGE_WIDTH_DEF;
  localparam int RW          = acs_pkg::REQ_W;
  localparam int IW          = acs_pkg::IDX_PORT_W;
  localparam int LW          = acs_pkg::LAT_W;
  localparam int CW          = acs_pkg::CFG_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * N + 8;
  localparam int PHASES      = 6;
  localparam int PER_PHASE   = 225;
  localparam int PRINT_CAP   = 60;

  localparam logic [RW-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [RW-1:0] REQ_UNUSED_B = 3'd7;

  localparam logic signed [AW-1:0] AGE_TOP = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [LW-1:0] LAT_TOP = 16'sh7FFF;
  localparam logic signed [LW-1:0] LAT_BOT = 16'sh8000;

  typedef struct packed {
    logic [RW-1:0]        req;
    logic [IW-1:0]        idx;
    logic signed [LW-1:0] lat;
    logic                 flag;
  } sel_cmd_t;

  typedef struct packed {
    logic          hit;
    logic [IW-1:0] idx;
  } sel_choice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RW-1:0] in_req_type = '0;
  logic [IW-1:0] in_entry_index = '0;
  logic signed [LW-1:0] in_latency_value = '0;
  logic in_flag = 1'b0;
  logic cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_chosen_valid;
  logic [IW-1:0] out_chosen_index;

  always #1 clk = ~clk;

  aging_checkpoint_selector DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_latency_value (in_latency_value),
    .in_flag          (in_flag),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_chosen_valid (out_chosen_valid),
    .out_chosen_index (out_chosen_index)
  );

  // table model
  bit tab_valid [N];
  bit tab_scratch [N];
  bit tab_dirty [N];
  logic signed [AW-1:0] tab_age [N];
  logic signed [AW-1:0] tab_bias [N];
  logic [CW-1:0] tb_latency = acs_pkg::CFG_LATENCY_RESET;

  sel_cmd_t cmd_q [$];
  sel_choice_t exp_choice_q [$];
  sel_cmd_t cur_cmd;
  bit [N-1:0] gen_open = '0;
  int idle_pct = 0;
  int n_errors = 0;
  int n_accepted = 0;
  int n_ticks = 0;
  int n_picks = 0;
  int n_settings = 1;
  int quiet_cycles = 0;

  task automatic report_mismatch(string what, int exp_v, int got_v);
    if (n_errors < PRINT_CAP) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    end
    n_errors++;
  endtask

  function automatic sel_choice_t predict_choice(sel_cmd_t c);
    sel_choice_t r;
    int best;
    bit live;
    r = '0;
    live = tab_valid[c.idx];
    case (c.req)
      acs_pkg::REQ_TICK: begin
        best = int'(tb_latency) - 1;
        for (int i = 0; i < N; i++) begin
          if (tab_valid[i] && !tab_scratch[i] && tab_dirty[i]) begin
            if (int'(tab_age[i]) > best) begin
              best = int'(tab_age[i]);
              r.hit = 1'b1;
              r.idx = i[IW-1:0];
            end
            if (tab_age[i] != AGE_TOP) tab_age[i] = tab_age[i] + AW'(1);
          end
        end
      end
      acs_pkg::REQ_OPEN: begin
        tab_valid[c.idx] = 1'b1;
        tab_scratch[c.idx] = c.flag;
        tab_dirty[c.idx] = 1'b0;
        tab_age[c.idx] = '0;
        tab_bias[c.idx] = '0;
      end
      acs_pkg::REQ_MODIFY: begin
        if (live) tab_dirty[c.idx] = 1'b1;
      end
      acs_pkg::REQ_OUTCOME: begin
        if (live && c.flag) begin
          tab_dirty[c.idx] = 1'b0;
          tab_age[c.idx] = tab_bias[c.idx];
        end
      end
      acs_pkg::REQ_SET_LAT: begin
        if (live) begin
          tab_bias[c.idx] = c.lat;
          tab_age[c.idx] = c.lat;
        end
      end
      acs_pkg::REQ_CLOSE: begin
        if (live) tab_valid[c.idx] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        exp_choice_q.push_back(predict_choice(cur_cmd));
        n_accepted++;
        if (cur_cmd.req == acs_pkg::REQ_TICK) n_ticks++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          in_req_type <= cur_cmd.req;
          in_entry_index <= cur_cmd.idx;
          in_latency_value <= cur_cmd.lat;
          in_flag <= cur_cmd.flag;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    sel_choice_t e;
    if (rst_n && out_valid) begin
      if (exp_choice_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 1);
      end else begin
        e = exp_choice_q.pop_front();
        if (out_chosen_valid !== e.hit)
          report_mismatch("chosen_valid", int'(e.hit), int'(out_chosen_valid));
        if (out_chosen_index !== e.idx)
          report_mismatch("chosen_index", int'(e.idx), int'(out_chosen_index));
        if (e.hit) n_picks++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(logic [RW-1:0] req, int idx, logic signed [LW-1:0] lat,
                           logic flag);
    sel_cmd_t c;
    c.req = req;
    c.idx = idx[IW-1:0];
    c.lat = lat;
    c.flag = flag;
    if (req == acs_pkg::REQ_OPEN) gen_open[c.idx] = 1'b1;
    if (req == acs_pkg::REQ_CLOSE) gen_open[c.idx] = 1'b0;
    cmd_q.push_back(c);
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || exp_choice_q.size() != 0);
  endtask

  task automatic write_latency(logic [CW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tb_latency = v;
    n_settings++;
  endtask

  function automatic logic signed [LW-1:0] rand_lat();
    int v;
    int raw;
    v = int'(tb_latency) + $urandom_range(6) - 3;
    raw = $urandom_range(16'hFFFF);
    case ($urandom_range(9))
      0: return LAT_TOP;
      1: return LAT_BOT;
      2, 3: return raw[LW-1:0];
      default: return v[LW-1:0];
    endcase
  endfunction

  function automatic int rand_index();
    int idx;
    if (gen_open != '0 && $urandom_range(99) < 85) begin
      do idx = $urandom_range(N - 1);
      while (!gen_open[idx]);
    end else begin
      idx = $urandom_range(N - 1);
    end
    return idx;
  endfunction

  task automatic queue_random(int count);
    int done;
    int r;
    int idx;
    logic [RW-1:0] req;
    logic flag;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      idx = rand_index();
      flag = ($urandom_range(1) != 0);
      if (r < 30) req = acs_pkg::REQ_TICK;
      else if (r < 40) begin
        req = acs_pkg::REQ_OPEN;
        flag = ($urandom_range(99) < 15);
      end else if (r < 58) req = acs_pkg::REQ_MODIFY;
      else if (r < 72) begin
        req = acs_pkg::REQ_OUTCOME;
        flag = ($urandom_range(99) < 75);
      end else if (r < 85) req = acs_pkg::REQ_SET_LAT;
      else if (r < 92) req = acs_pkg::REQ_CLOSE;
      else if (r < 96) req = $urandom_range(1) ? REQ_UNUSED_A : REQ_UNUSED_B;
      else req = acs_pkg::REQ_MODIFY;
      done++;
      queue_cmd(req, idx, rand_lat(), flag);
    end
  endtask

  task automatic queue_directed();
    queue_cmd(acs_pkg::REQ_TICK, 0, LAT_TOP, 1'b1);
    queue_cmd(acs_pkg::REQ_OPEN, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_OPEN, 15, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_OPEN, 7, 16'sd0, 1'b1);
    queue_cmd(acs_pkg::REQ_MODIFY, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_MODIFY, 15, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_MODIFY, 7, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_MODIFY, 3, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_SET_LAT, 0, LAT_TOP, 1'b0);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_SET_LAT, 15, LAT_TOP, 1'b1);
    queue_cmd(acs_pkg::REQ_TICK, 15, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_OUTCOME, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_OUTCOME, 0, 16'sd0, 1'b1);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_SET_LAT, 15, LAT_BOT, 1'b0);
    queue_cmd(REQ_UNUSED_A, 15, LAT_TOP, 1'b1);
    queue_cmd(REQ_UNUSED_B, 15, LAT_TOP, 1'b1);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_CLOSE, 15, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_MODIFY, 15, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_SET_LAT, 7, 16'sd100, 1'b0);
    queue_cmd(acs_pkg::REQ_OUTCOME, 3, 16'sd0, 1'b1);
    queue_cmd(acs_pkg::REQ_OPEN, 0, 16'sd0, 1'b0);
    queue_cmd(acs_pkg::REQ_TICK, 0, 16'sd0, 1'b0);
  endtask

  initial begin
    int phase_lat [PHASES];
    int phase_idle [PHASES];
    int pick_lat;
    phase_lat = '{-1, 0, 255, -2, 1, 4};
    phase_idle = '{0, 75, 0, 32, 75, 32};
    for (int i = 0; i < N; i++) begin
      tab_valid[i] = 1'b0;
      tab_scratch[i] = 1'b0;
      tab_dirty[i] = 1'b0;
      tab_age[i] = '0;
      tab_bias[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      drain_all();
      if (phase_lat[p] == -2) begin
        pick_lat = $urandom_range(2, 254);
        write_latency(pick_lat[CW-1:0]);
      end else if (phase_lat[p] >= 0) begin
        pick_lat = phase_lat[p];
        write_latency(pick_lat[CW-1:0]);
      end
      idle_pct = phase_idle[p];
      if (p == 0) queue_directed();
      queue_random(PER_PHASE);
    end
    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_choice_q.size() != 0)
      report_mismatch("results never returned", exp_choice_q.size(), 0);
    $display("run covered %0d command beats, %0d ticks and %0d checkpoint picks",
             n_accepted, n_ticks, n_picks);
    $display("over %0d global latency settings, %0d mismatches", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
